>>> rtl/core/prms_pkg.sv
// shared types, constants and bound table for the rate-monotonic scheduler
package prms_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int CPUS_DEF      = 4;

    localparam int EXEC_W  = 16;
    localparam int PER_W   = 16;
    localparam int REM_W   = 24;
    localparam int UTIL_W  = 20;
    localparam int CNT_W   = 5;
    localparam int MISS_W  = 16;
    localparam int CPUF_W  = 4;
    localparam int QUO_W   = 32;
    localparam int FRAC_W  = 16;

    localparam logic [UTIL_W-1:0] UTIL_MAX = '1;
    localparam logic [REM_W-1:0]  REM_MAX  = '1;
    localparam logic [MISS_W-1:0] MISS_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef struct packed {
        logic [EXEC_W-1:0] exec_time;
        logic [PER_W-1:0]  period;
        logic [CPUF_W-1:0] cpu;
        logic [REM_W-1:0]  remaining;
        logic [PER_W-1:0]  countdown;
    } task_t;

    // n*(2^(1/n)-1) in q4.16, rounded
    function automatic logic [UTIL_W-1:0] ll_bound(input logic [CNT_W-1:0] n);
        logic [UTIL_W-1:0] b;
        begin
            case (n)
                5'd1:    b = 20'd65536;
                5'd2:    b = 20'd54292;
                5'd3:    b = 20'd51103;
                5'd4:    b = 20'd49600;
                5'd5:    b = 20'd48725;
                5'd6:    b = 20'd48154;
                5'd7:    b = 20'd47751;
                5'd8:    b = 20'd47452;
                5'd9:    b = 20'd47221;
                5'd10:   b = 20'd47037;
                5'd11:   b = 20'd46888;
                5'd12:   b = 20'd46764;
                5'd13:   b = 20'd46659;
                5'd14:   b = 20'd46569;
                5'd15:   b = 20'd46492;
                5'd16:   b = 20'd46424;
                5'd17:   b = 20'd46365;
                5'd18:   b = 20'd46312;
                5'd19:   b = 20'd46265;
                5'd20:   b = 20'd46222;
                5'd21:   b = 20'd46184;
                5'd22:   b = 20'd46149;
                5'd23:   b = 20'd46118;
                5'd24:   b = 20'd46088;
                5'd25:   b = 20'd46062;
                5'd26:   b = 20'd46037;
                5'd27:   b = 20'd46014;
                5'd28:   b = 20'd45993;
                5'd29:   b = 20'd45973;
                5'd30:   b = 20'd45955;
                5'd31:   b = 20'd45938;
                default: b = 20'd0;
            endcase
            return b;
        end
    endfunction

endpackage

>>> rtl/core/prms_div.sv
// iterative restoring divider, one quotient bit per cycle
module prms_div
    import prms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [QUO_W-1:0]   dividend,
    input  logic [PER_W-1:0]   divisor,
    output logic               done,
    output logic [QUO_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [PER_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [PER_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PER_W:0]    shifted;
    logic [PER_W:0]    diff;
    logic              qbit;

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign qbit    = (shifted >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[PER_W-1:0] : shifted[PER_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/prms_task_ram.sv
// task table memory, one write and one registered read per cycle
module prms_task_ram
    import prms_pkg::*;
#(
    parameter int DEPTH = MAX_TASKS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  task_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output task_t         rd_data
);

    task_t mem [DEPTH];
    task_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

>>> rtl/core/partitioned_rate_monotonic_scheduler_top.sv
// top level of the partitioned rate-monotonic scheduler
//
// input channel in_valid/in_ready carries mode, exec_time and period.
// mode 0 adds a task: it is bound to the cpu with least utilization and
// one result transaction returns cpu, task number and the bound check.
// a full table returns status 1 at once.
// mode 1 is one tick: every task is released or counted down, then each
// cpu runs its shortest-period ready task; CPUS result transactions follow,
// last set on the final one.
// in_ready is high only while no item is in work; out_valid holds the
// result until out_ready takes it, a stalled receiver simply holds the block.
// an add scans the cpus, then runs the 32-step divider for the utilization.
// a tick reads and rewrites each stored task through the table memory port,
// then reads and decrements the remaining time of the picked task of each
// running cpu, then sends one result per cpu.
// reset clears counts, sums and the miss counter; no clearing pass needed.
module partitioned_rate_monotonic_scheduler_top
    import prms_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int CPUS      = CPUS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [15:0] exec_time,
    input  logic [15:0] period,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  cpu,
    output logic [4:0]  task_res,
    output logic        status,
    output logic        schedulable,
    output logic [15:0] missed_total,
    output logic        last
);

    localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TW1 = $clog2(MAX_TASKS + 1);
    localparam int CW  = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int CW1 = $clog2(CPUS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_SEL = 4'd1;
    localparam logic [3:0] S_ADD_DIV = 4'd2;
    localparam logic [3:0] S_RES     = 4'd3;
    localparam logic [3:0] S_TK_RD   = 4'd4;
    localparam logic [3:0] S_TK_UPD  = 4'd5;
    localparam logic [3:0] S_DEC_RD  = 4'd6;
    localparam logic [3:0] S_DEC_WR  = 4'd7;
    localparam logic [3:0] S_TK_OUT  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [EXEC_W-1:0] exec_reg;
    logic [PER_W-1:0]  per_reg;
    logic [TW1-1:0]    tcount_reg;
    logic [TW1-1:0]    idx_reg;
    logic [CW1-1:0]    c_reg;
    logic [CW-1:0]     best_reg;
    logic [UTIL_W-1:0] util_reg [CPUS];
    logic [CNT_W-1:0]  cnt_reg [CPUS];
    logic              found_reg [CPUS];
    logic [TW-1:0]     pick_reg [CPUS];
    logic [PER_W-1:0]  pper_reg [CPUS];
    logic              first_reg;
    logic [MISS_W-1:0] miss_reg;
    logic [CW-1:0]     res_cpu_reg;
    logic [4:0]        res_task_reg;
    logic              res_status_reg;

    logic              in_acc, out_acc;
    logic [CW-1:0]     ci, sci, dcpu;
    logic              div_start, div_done;
    logic [QUO_W-1:0]  div_q;
    logic [UTIL_W-1:0] util_task;
    logic [UTIL_W:0]   util_sum;
    logic [UTIL_W-1:0] util_new;
    task_t             rd_data, wr_data;
    logic              wr_en, rd_en;
    logic [TW-1:0]     wr_addr, rd_addr;
    logic              due;
    logic [REM_W:0]    rel_sum;
    logic [REM_W-1:0]  new_rem;
    logic              miss_inc, better, sel_better;
    logic [CW-1:0]     oc;
    logic              ok;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign ci      = c_reg[CW-1:0];
    assign sci     = c_reg[CW-1:0];

    assign sel_better = (util_reg[sci] < util_reg[best_reg]) ||
                        ((util_reg[sci] == util_reg[best_reg]) &&
                         (cnt_reg[sci] < cnt_reg[best_reg]));

    assign div_start = (state_reg == S_ADD_SEL) && (c_reg >= CW1'(CPUS));

    prms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({exec_reg, {FRAC_W{1'b0}}}),
        .divisor  (per_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign util_task = (div_q[QUO_W-1:UTIL_W] != '0) ? UTIL_MAX : div_q[UTIL_W-1:0];
    assign util_sum  = {1'b0, util_reg[best_reg]} + {1'b0, util_task};
    assign util_new  = util_sum[UTIL_W] ? UTIL_MAX : util_sum[UTIL_W-1:0];

    // release and priority scan of one entry
    assign due      = (rd_data.countdown == '0);
    assign rel_sum  = {1'b0, rd_data.remaining} + (REM_W+1)'(rd_data.exec_time);
    assign new_rem  = due ? (rel_sum[REM_W] ? REM_MAX : rel_sum[REM_W-1:0])
                          : rd_data.remaining;
    assign miss_inc = due && first_reg && (rd_data.remaining != '0) &&
                      (miss_reg != MISS_MAX);
    assign dcpu     = rd_data.cpu[CW-1:0];
    assign better   = (new_rem != '0) &&
                      (!found_reg[dcpu] || (rd_data.period < pper_reg[dcpu]));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tcount_reg[TW-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = idx_reg[TW-1:0];
        case (state_reg)
            S_ADD_DIV:
            begin
                wr_en             = div_done;
                wr_data.exec_time = exec_reg;
                wr_data.period    = per_reg;
                wr_data.cpu       = CPUF_W'(best_reg);
                wr_data.remaining = '0;
                wr_data.countdown = '0;
            end
            S_TK_RD:
            begin
                rd_en = (idx_reg < tcount_reg);
            end
            S_TK_UPD:
            begin
                wr_en             = 1'b1;
                wr_addr           = idx_reg[TW-1:0];
                wr_data.remaining = new_rem;
                wr_data.countdown = due ? (rd_data.period - 1'b1)
                                        : (rd_data.countdown - 1'b1);
            end
            S_DEC_RD:
            begin
                rd_en   = (c_reg < CW1'(CPUS)) && found_reg[ci];
                rd_addr = pick_reg[ci];
            end
            S_DEC_WR:
            begin
                wr_en             = 1'b1;
                wr_addr           = pick_reg[ci];
                wr_data.remaining = rd_data.remaining - 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    prms_task_ram #(
        .DEPTH (MAX_TASKS),
        .AW    (TW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode)
                        state_next = S_TK_RD;
                    else if (tcount_reg >= TW1'(MAX_TASKS))
                        state_next = S_RES;
                    else
                        state_next = S_ADD_SEL;
                end
            end
            S_ADD_SEL:
            begin
                if (c_reg >= CW1'(CPUS))
                    state_next = S_ADD_DIV;
            end
            S_ADD_DIV:
            begin
                if (div_done)
                    state_next = S_RES;
            end
            S_RES:
            begin
                if (out_acc)
                    state_next = S_IDLE;
            end
            S_TK_RD:
            begin
                state_next = (idx_reg < tcount_reg) ? S_TK_UPD : S_DEC_RD;
            end
            S_TK_UPD:
            begin
                state_next = S_TK_RD;
            end
            S_DEC_RD:
            begin
                if (c_reg >= CW1'(CPUS))
                    state_next = S_TK_OUT;
                else if (found_reg[ci])
                    state_next = S_DEC_WR;
            end
            S_DEC_WR:
            begin
                state_next = S_DEC_RD;
            end
            S_TK_OUT:
            begin
                if (out_acc && (c_reg == CW1'(CPUS - 1)))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tcount_reg     <= '0;
            idx_reg        <= '0;
            c_reg          <= '0;
            best_reg       <= '0;
            first_reg      <= 1'b0;
            miss_reg       <= '0;
            res_status_reg <= 1'b0;
            for (int k = 0; k < CPUS; k++)
            begin
                util_reg[k]  <= '0;
                cnt_reg[k]   <= '0;
                found_reg[k] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg        <= '0;
                    c_reg          <= CW1'(1);
                    best_reg       <= '0;
                    res_status_reg <= (tcount_reg >= TW1'(MAX_TASKS));
                    for (int k = 0; k < CPUS; k++)
                    begin
                        found_reg[k] <= 1'b0;
                    end
                end
                S_ADD_SEL:
                begin
                    if (c_reg < CW1'(CPUS))
                    begin
                        if (sel_better)
                            best_reg <= sci;
                        c_reg <= c_reg + 1'b1;
                    end
                end
                S_ADD_DIV:
                begin
                    if (div_done)
                    begin
                        util_reg[best_reg] <= util_new;
                        if (cnt_reg[best_reg] != CNT_MAX)
                            cnt_reg[best_reg] <= cnt_reg[best_reg] + 1'b1;
                        tcount_reg <= tcount_reg + 1'b1;
                    end
                end
                S_TK_RD:
                begin
                    if (idx_reg >= tcount_reg)
                    begin
                        c_reg     <= '0;
                        first_reg <= 1'b1;
                    end
                end
                S_TK_UPD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (miss_inc)
                        miss_reg <= miss_reg + 1'b1;
                    if (better)
                        found_reg[dcpu] <= 1'b1;
                end
                S_DEC_RD:
                begin
                    if (c_reg >= CW1'(CPUS))
                        c_reg <= '0;
                    else if (!found_reg[ci])
                        c_reg <= c_reg + 1'b1;
                end
                S_DEC_WR:
                begin
                    c_reg <= c_reg + 1'b1;
                end
                S_TK_OUT:
                begin
                    if (out_acc)
                        c_reg <= c_reg + 1'b1;
                end
                default:
                begin
                    c_reg <= c_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            exec_reg <= exec_time;
            per_reg  <= (period == '0) ? PER_W'(1) : period;
        end
        if ((state_reg == S_TK_UPD) && better)
        begin
            pick_reg[dcpu] <= idx_reg[TW-1:0];
            pper_reg[dcpu] <= rd_data.period;
        end
        if (state_reg == S_IDLE)
        begin
            res_cpu_reg  <= '0;
            res_task_reg <= '0;
        end
        else if ((state_reg == S_ADD_DIV) && div_done)
        begin
            res_cpu_reg  <= best_reg;
            res_task_reg <= 5'(tcount_reg + 1'b1);
        end
    end

    // result fields
    assign oc = (state_reg == S_RES) ? res_cpu_reg : ci;
    assign ok = (cnt_reg[oc] == '0) || (util_reg[oc] <= ll_bound(cnt_reg[oc]));

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_RES) || (state_reg == S_TK_OUT);
    assign cpu          = 2'(oc);
    assign task_res     = (state_reg == S_RES) ? res_task_reg :
                          (found_reg[ci] ? (5'(pick_reg[ci]) + 5'd1) : 5'd0);
    assign status       = (state_reg == S_RES) && res_status_reg;
    assign schedulable  = !((state_reg == S_RES) && res_status_reg) && ok;
    assign missed_total = miss_reg;
    assign last         = (state_reg == S_RES) || (c_reg == CW1'(CPUS - 1));

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= TW1'(MAX_TASKS))
        else $error("task count beyond table depth");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not ready after final result");

    a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (miss_reg >= $past(miss_reg)))
        else $error("miss counter decreased");

endmodule
